// File: src/bfba_pkg.sv
package bfba_pkg;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  typedef struct packed {
    logic        func;
    logic [4:0]  block_index;
    logic [15:0] size_value;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [4:0]  chosen_block;
    logic [15:0] fragment_left;
  } out_word_t;

  typedef struct packed {
    logic load_en;
    logic alloc_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } bfba_state_t;

endpackage

// File: src/bfba_cell.sv
module bfba_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 5,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfba_pkg::cell_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]       sel_idx,
  input  logic [SIZE_WIDTH-1:0]  wr_size,
  input  logic [SIZE_WIDTH-1:0]  req_size,
  input  logic [5:0]             active,
  input  bfba_pkg::tok_flags_t   tok_flags_in,
  input  logic [IDX_W-1:0]       tok_idx_in,
  input  logic [SIZE_WIDTH-1:0]  tok_size_in,
  output bfba_pkg::tok_flags_t   tok_flags_out,
  output logic [IDX_W-1:0]       tok_idx_out,
  output logic [SIZE_WIDTH-1:0]  tok_size_out
);
  import bfba_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_WIDTH-1:0] size_r;
  logic                  used_r;
  tok_flags_t            tok_flags_r;
  logic [IDX_W-1:0]      tok_idx_r;
  logic [SIZE_WIDTH-1:0] tok_size_r;

  logic                  is_active;
  logic                  hit;
  logic                  selected;
  tok_flags_t            tok_flags_nxt;
  logic [IDX_W-1:0]      tok_idx_nxt;
  logic [SIZE_WIDTH-1:0] tok_size_nxt;

  always_comb begin
    is_active = 32'(active) > 32'(CELL_IDX);
    selected  = sel_idx == MY_IDX;
    hit = tok_flags_in.valid && is_active && !used_r && (size_r >= req_size) &&
          (!tok_flags_in.found || (size_r < tok_size_in));
    tok_flags_nxt.valid = tok_flags_in.valid;
    tok_flags_nxt.found = tok_flags_in.found || hit;
    tok_idx_nxt         = hit ? MY_IDX : tok_idx_in;
    tok_size_nxt        = hit ? size_r : tok_size_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      tok_flags_r <= '0;
    end else begin
      tok_flags_r <= tok_flags_nxt;
      if (ctrl.load_en && selected) begin
        used_r <= 1'b0;
      end else if (ctrl.alloc_en && selected) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_idx_r  <= tok_idx_nxt;
    tok_size_r <= tok_size_nxt;
    if (ctrl.load_en && selected) begin
      size_r <= wr_size;
    end
  end

  assign tok_flags_out = tok_flags_r;
  assign tok_idx_out   = tok_idx_r;
  assign tok_size_out  = tok_size_r;

endmodule

// File: src/best_fit_block_allocator_core.sv
// Channel   Ports                          Handshake
// input     start, busy, in_word           taken when start is high and busy is low
// result    out_valid, out_word            shown for one cycle, cannot be stalled
// config    cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready are high
//
// A load word writes its cell at once and is acknowledged on the next cycle.
// A request word sends a search token down the row of MAX_BLOCKS cells, one cell per
// cycle, and its result is registered once the token has left the last cell.
// Busy is high while the token travels; a new word may be started in the cycle the
// result is shown. Reset is synchronous and active low and frees every block.
// A configuration write waits while busy or start is high.
module best_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = 32,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfba_pkg::in_word_t  in_word,
  output logic                out_valid,
  output bfba_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  import bfba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  bfba_state_t           state_r, state_nxt;
  logic [5:0]            active_r;
  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;

  logic                  accept;
  logic [SIZE_WIDTH-1:0] in_size;
  logic [SIZE_WIDTH-1:0] req_bus;
  logic [IDX_W-1:0]      sel_idx;
  cell_ctrl_t            ctrl;

  tok_flags_t            tok_flags [MAX_BLOCKS+1];
  logic [IDX_W-1:0]      tok_idx   [MAX_BLOCKS+1];
  logic [SIZE_WIDTH-1:0] tok_size  [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] tok_valid_vec;

  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign in_size   = SIZE_WIDTH'(in_word.size_value);
  assign req_bus   = busy ? req_r : in_size;

  assign tok_flags[0].valid = accept && (in_word.func == FUNC_REQUEST);
  assign tok_flags[0].found = 1'b0;
  assign tok_idx[0]         = '0;
  assign tok_size[0]        = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    bfba_cell #(
      .CELL_IDX   (k),
      .IDX_W      (IDX_W),
      .SIZE_WIDTH (SIZE_WIDTH)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (ctrl),
      .sel_idx       (sel_idx),
      .wr_size       (in_size),
      .req_size      (req_bus),
      .active        (active_r),
      .tok_flags_in  (tok_flags[k]),
      .tok_idx_in    (tok_idx[k]),
      .tok_size_in   (tok_size[k]),
      .tok_flags_out (tok_flags[k+1]),
      .tok_idx_out   (tok_idx[k+1]),
      .tok_size_out  (tok_size[k+1])
    );
    assign tok_valid_vec[k] = tok_flags[k+1].valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    ctrl          = '0;
    sel_idx       = IDX_W'(in_word.block_index);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_LOAD) begin
            ctrl.load_en  = 32'(in_word.block_index) < MAX_BLOCKS;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{granted: 1'b1, chosen_block: '0, fragment_left: '0};
          end else begin
            req_nxt   = in_size;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        sel_idx = tok_idx[MAX_BLOCKS];
        if (tok_flags[MAX_BLOCKS].valid) begin
          ctrl.alloc_en = tok_flags[MAX_BLOCKS].found;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (tok_flags[MAX_BLOCKS].found) begin
            out_word_nxt.granted       = 1'b1;
            out_word_nxt.chosen_block  = 5'(tok_idx[MAX_BLOCKS]);
            out_word_nxt.fragment_left = 16'(tok_size[MAX_BLOCKS] - req_r);
          end else begin
            out_word_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_out_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_SCAN) ||
                  $past(start && !busy && in_word.func == FUNC_LOAD))
    else $error("result strobe without a finished scan or load");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid_vec) == ((state_r == ST_SCAN) ? 1 : 0))
    else $error("search token count does not match scan state");

  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.granted) |-> (out_word.chosen_block == 5'd0) &&
                                         (out_word.fragment_left == 16'd0))
    else $error("refused request carries nonzero fields");

endmodule

// File: tb/sv/best_fit_block_allocator_core_checker.sv
`timescale 1ns / 100ps
module best_fit_block_allocator_core_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bfba_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  bfba_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  output int                  mismatch_count,
  output int                  pending,
  output int                  grant_count,
  output int                  refuse_count
);
  import bfba_pkg::*;

  localparam int BLOCKS = 32;

  logic [15:0] size_tbl [BLOCKS];
  bit          used_tbl [BLOCKS];
  logic [5:0]  active_cnt;
  out_word_t   grant_q [$];

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic out_word_t predict_grant(input in_word_t w);
    out_word_t r;
    int lim;
    int pick;
    bit hit;
    r = '0;
    pick = 0;
    hit = 1'b0;
    if (w.func == FUNC_LOAD) begin
      size_tbl[w.block_index] = w.size_value;
      used_tbl[w.block_index] = 1'b0;
      r.granted = 1'b1;
      return r;
    end
    lim = (active_cnt > BLOCKS) ? BLOCKS : int'(active_cnt);
    for (int i = 0; i < lim; i++) begin
      if (!used_tbl[i] && size_tbl[i] >= w.size_value) begin
        if (!hit || size_tbl[i] < size_tbl[pick]) begin
          pick = i;
          hit = 1'b1;
        end
      end
    end
    if (hit) begin
      used_tbl[pick] = 1'b1;
      r.granted = 1'b1;
      r.chosen_block = 5'(pick);
      r.fragment_left = size_tbl[pick] - w.size_value;
      grant_count++;
    end else begin
      refuse_count++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      grant_q.delete();
      active_cnt = '0;
      for (int i = 0; i < BLOCKS; i++) begin
        size_tbl[i] = '0;
        used_tbl[i] = 1'b0;
      end
    end else begin
      if (out_valid === 1'b1) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("result word with nothing expected", out_word, 0);
        end else begin
          want = grant_q.pop_front();
          if (out_word.granted !== want.granted)
            flag_mismatch("granted", out_word.granted, want.granted);
          if (out_word.chosen_block !== want.chosen_block)
            flag_mismatch("chosen_block", out_word.chosen_block, want.chosen_block);
          if (out_word.fragment_left !== want.fragment_left)
            flag_mismatch("fragment_left", out_word.fragment_left, want.fragment_left);
        end
      end
      if (cfg_valid && cfg_ready === 1'b1)
        active_cnt = cfg_data;
      if (start && busy === 1'b0)
        grant_q.push_back(predict_grant(in_word));
    end
    pending <= grant_q.size();
  end

endmodule

// File: tb/sv/best_fit_block_allocator_core_test.sv
`timescale 1ns / 100ps
module best_fit_block_allocator_core_test;
  import bfba_pkg::*;

  localparam int BLOCKS = 32;
  localparam int PHASE_WORDS = 130;
  localparam logic [5:0] ACTIVE_STEPS [12] = '{6'd1, 6'd32, 6'd63, 6'd2, 6'd33, 6'd8,
                                               6'd16, 6'd31, 6'd0, 6'd5, 6'd42, 6'd21};

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       out_valid;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [5:0] cfg_data;

  int mismatch_count;
  int pending;
  int grant_count;
  int refuse_count;

  bit loaded [BLOCKS];
  bit gaps_on;
  int active_now;
  int load_count;
  int request_count;
  int setting_count;

  best_fit_block_allocator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  best_fit_block_allocator_core_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_word       (out_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .grant_count    (grant_count),
    .refuse_count   (refuse_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(0, 15) * 64);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input logic func, input logic [4:0] idx, input logic [15:0] size);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= '{func: func, block_index: idx, size_value: size};
    do @(posedge clk); while (busy);
    if (func == FUNC_LOAD) begin
      loaded[idx] = 1'b1;
      load_count++;
    end else begin
      request_count++;
    end
  endtask

  task automatic write_active(input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    active_now = int'(value);
    setting_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    for (int k = 0; k < 5000 && pending != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A request never scans an active entry that has not been loaded yet.
  task automatic random_item();
    int lim;
    int hole;
    int span;
    lim = (active_now > BLOCKS) ? BLOCKS : active_now;
    hole = -1;
    for (int i = lim - 1; i >= 0; i--) begin
      if (!loaded[i]) hole = i;
    end
    span = (lim > 0) ? lim : BLOCKS;
    if (hole >= 0) begin
      send_word(FUNC_LOAD, 5'(hole), pick_size());
    end else if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 99) < 85)
        send_word(FUNC_LOAD, 5'($urandom_range(0, span - 1)), pick_size());
      else
        send_word(FUNC_LOAD, 5'($urandom_range(0, BLOCKS - 1)), pick_size());
    end else begin
      send_word(FUNC_REQUEST, 5'($urandom_range(0, BLOCKS - 1)), pick_size());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(FUNC_REQUEST, 5'd0, 16'd0);
    send_word(FUNC_LOAD, 5'd31, 16'hFFFF);
    send_word(FUNC_LOAD, 5'd0, 16'd0);
    send_word(FUNC_LOAD, 5'd1, 16'd100);
    send_word(FUNC_LOAD, 5'd2, 16'd100);
    send_word(FUNC_LOAD, 5'd3, 16'd300);
    drain();
    write_active(6'd4);
    send_word(FUNC_REQUEST, 5'd31, 16'd100);
    send_word(FUNC_REQUEST, 5'd0, 16'd50);
    send_word(FUNC_REQUEST, 5'd7, 16'd0);
    send_word(FUNC_REQUEST, 5'd0, 16'd301);
    send_word(FUNC_REQUEST, 5'd0, 16'd300);
    send_word(FUNC_REQUEST, 5'd0, 16'd0);
    send_word(FUNC_LOAD, 5'd2, 16'd200);
    send_word(FUNC_REQUEST, 5'd0, 16'd1);
    send_word(FUNC_REQUEST, 5'd0, 16'hFFFF);
    send_word(FUNC_LOAD, 5'd0, 16'hFFFF);
    send_word(FUNC_REQUEST, 5'd0, 16'hFFFF);
    drain();

    for (int p = 0; p < 15; p++) begin
      write_active((p < 12) ? ACTIVE_STEPS[p] : 6'($urandom_range(0, 63)));
      gaps_on = (p != 3 && p != 4);
      repeat (PHASE_WORDS) random_item();
      drain();
    end
    repeat (40) @(posedge clk);

    $display("Sent %0d words, %0d loads and %0d requests, under %0d active_blocks settings.",
             load_count + request_count, load_count, request_count, setting_count);
    $display("Requests granted %0d, refused %0d.", grant_count, refuse_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
